[src/idiv128_pkg.sv]
package idiv128_pkg;

    // Operand width of the divider; the port halves are fixed at 64 bits.
    localparam int OPERAND_BITS = 128;
    localparam int WORD_BITS    = 64;
    localparam int FULL_BITS    = 2 * WORD_BITS;

    // Operation codes carried on the cmd field.
    localparam logic CMD_UNSIGNED = 1'b0;
    localparam logic CMD_SIGNED   = 1'b1;

    typedef logic [OPERAND_BITS-1:0] operand_t;

    // One word in flight through the division array.
    // The aq field starts as the dividend magnitude.
    // Each step shifts one dividend bit out of its top and one quotient bit into its bottom.
    typedef struct packed {
        logic     valid;
        logic     neg_quo;
        logic     neg_rem;
        logic     div_zero;
        operand_t rem;
        operand_t aq;
        operand_t divisor;
    } stage_t;

    function automatic operand_t negate(input operand_t v);
        negate = operand_t'(~v + operand_t'(1));
    endfunction

endpackage

[src/idiv128_step.sv]
module idiv128_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  idiv128_pkg::stage_t stage_in,
    output idiv128_pkg::stage_t stage_out
);
    import idiv128_pkg::*;

    logic [OPERAND_BITS:0] partial;
    logic [OPERAND_BITS:0] diff;
    logic                  qbit;
    stage_t                stage_next;
    stage_t                data_reg;
    logic                  valid_reg;

    // One restoring step: shift in the next dividend bit, then subtract the
    // divisor when the partial remainder is large enough.
    always_comb begin
        partial    = {stage_in.rem, stage_in.aq[OPERAND_BITS-1]};
        diff       = partial - {1'b0, stage_in.divisor};
        qbit       = ~diff[OPERAND_BITS];
        stage_next = stage_in;
        stage_next.rem = qbit ? diff[OPERAND_BITS-1:0] : partial[OPERAND_BITS-1:0];
        stage_next.aq  = {stage_in.aq[OPERAND_BITS-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= stage_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= stage_next;
        end
    end

    always_comb begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

[src/integer_divider_128_core.sv]
// Pipeline: the input register, the one-bit restoring step registers, then the output register.
// Throughput: one division per cycle while the skid register is empty, from 128 one-bit restoring stages.
// Each stage does one 129-bit subtract and compare.
// Reset: aresetn is synchronous and active low, and it clears every valid bit.
// Reset does not clear the data registers.
module integer_divider_128_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic [idiv128_pkg::WORD_BITS-1:0]    s_dividend_high,
    input  logic [idiv128_pkg::WORD_BITS-1:0]    s_dividend_low,
    input  logic [idiv128_pkg::WORD_BITS-1:0]    s_divisor_high,
    input  logic [idiv128_pkg::WORD_BITS-1:0]    s_divisor_low,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [idiv128_pkg::WORD_BITS-1:0]    m_quotient_high,
    output logic [idiv128_pkg::WORD_BITS-1:0]    m_quotient_low,
    output logic [idiv128_pkg::WORD_BITS-1:0]    m_remainder_high,
    output logic [idiv128_pkg::WORD_BITS-1:0]    m_remainder_low,
    output logic                                 m_divide_by_zero
);
    import idiv128_pkg::*;

    typedef struct packed {
        logic [FULL_BITS-1:0] quo;
        logic [FULL_BITS-1:0] rem;
        logic                 div_zero;
    } result_t;

    // The whole array advances together.
    // It stops only when the skid register is holding a word.
    // That happens when the output register was stalled while a new result arrived.
    logic    en;

    logic [FULL_BITS-1:0] dividend_full;
    logic [FULL_BITS-1:0] divisor_full;
    operand_t a_val;
    operand_t b_val;
    logic     is_signed;
    logic     sign_a;
    logic     sign_b;
    stage_t   pre_next;
    stage_t   pre_data_reg;
    logic     pre_valid_reg;

    stage_t   chain [0:OPERAND_BITS];

    operand_t quo_fix;
    operand_t rem_fix;
    result_t  post_result;
    logic     push;

    result_t  out_reg;
    result_t  out_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    result_t  skid_reg;
    result_t  skid_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;

    assign en      = ~skid_valid_reg;
    assign s_ready = en;

    // Input stage: take magnitudes in signed mode and record the signs to put back later.
    // A zero divisor runs through the array unsigned.
    // With a zero divisor the restoring steps give an all-ones quotient and return the dividend as the remainder.
    // That is exactly the result required for division by zero.
    always_comb begin
        dividend_full = {s_dividend_high, s_dividend_low};
        divisor_full  = {s_divisor_high, s_divisor_low};
        a_val         = dividend_full[OPERAND_BITS-1:0];
        b_val         = divisor_full[OPERAND_BITS-1:0];
        pre_next.div_zero = (b_val == '0);
        is_signed     = (s_cmd == CMD_SIGNED) && !pre_next.div_zero;
        sign_a        = is_signed && a_val[OPERAND_BITS-1];
        sign_b        = is_signed && b_val[OPERAND_BITS-1];
        pre_next.valid    = s_valid;
        pre_next.neg_quo  = sign_a ^ sign_b;
        pre_next.neg_rem  = sign_a;
        pre_next.rem      = '0;
        pre_next.aq       = sign_a ? negate(a_val) : a_val;
        pre_next.divisor  = sign_b ? negate(b_val) : b_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (en) begin
            pre_valid_reg <= pre_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_data_reg <= pre_next;
        end
    end

    always_comb begin
        chain[0]       = pre_data_reg;
        chain[0].valid = pre_valid_reg;
    end

    // One registered restoring step per quotient bit, most significant bit first.
    for (genvar k = 0; k < OPERAND_BITS; k++) begin : g_step
        idiv128_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .stage_in  (chain[k]),
            .stage_out (chain[k+1])
        );
    end

    // Sign fix-up ahead of the output register.
    // The quotient is negated when the operand signs differ.
    // The remainder follows the sign of the dividend.
    always_comb begin
        quo_fix = chain[OPERAND_BITS].neg_quo ? negate(chain[OPERAND_BITS].aq)
                                              : chain[OPERAND_BITS].aq;
        rem_fix = chain[OPERAND_BITS].neg_rem ? negate(chain[OPERAND_BITS].rem)
                                              : chain[OPERAND_BITS].rem;
        post_result.quo      = FULL_BITS'(quo_fix);
        post_result.rem      = FULL_BITS'(rem_fix);
        post_result.div_zero = chain[OPERAND_BITS].div_zero;
        push                 = en && chain[OPERAND_BITS].valid;
    end

    // Output register with one skid word behind it.
    // A result that finishes while the output is stalled parks in the skid register.
    // The array then holds until the skid word has moved forward.
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = post_result;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_next       = post_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_quotient_high  = out_reg.quo[FULL_BITS-1:WORD_BITS];
    assign m_quotient_low   = out_reg.quo[WORD_BITS-1:0];
    assign m_remainder_high = out_reg.rem[FULL_BITS-1:WORD_BITS];
    assign m_remainder_low  = out_reg.rem[WORD_BITS-1:0];
    assign m_divide_by_zero = out_reg.div_zero;

    // The skid register is filled only behind a stalled output word.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with no output word");

    // A parked word is never dropped: the output stays valid in the next cycle.
    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |=> m_valid)
        else $error("skid word lost");

    // While the array is held, its last stage must not move.
    a_array_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(chain[OPERAND_BITS]))
        else $error("array advanced while held");

    // A zero divisor always yields an all-ones quotient within the operand width.
    a_zero_quotient: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_divide_by_zero) |->
        ({m_quotient_high, m_quotient_low} == FULL_BITS'({OPERAND_BITS{1'b1}})))
        else $error("bad quotient on division by zero");

endmodule
